/* rtl/hid_key_knob_scanner_core_defines.svh */
// ----------------------------------------------------------------------------
// Key and knob scanner assertion macros
// Shared helpers for the concurrent checks of the scanner core.
// ----------------------------------------------------------------------------
`ifndef HID_KEY_KNOB_SCANNER_CORE_DEFINES_SVH
`define HID_KEY_KNOB_SCANNER_CORE_DEFINES_SVH

// Concurrent check sampled on the rising clock edge, muted while reset is low.
`define HKKS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with no reset qualifier, for properties that hold in reset too.
`define HKKS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hkks_pkg.sv */
// ----------------------------------------------------------------------------
// Key and knob scanner package
// Types, field widths and register addresses shared by the scanner files.
// ----------------------------------------------------------------------------
`default_nettype none

package hkks_pkg;

  // Stream field widths.
  localparam int unsigned TS_W       = 32;
  localparam int unsigned FUN_LVL_W  = 6;
  localparam int unsigned MTX_W      = 16;
  localparam int unsigned ENC_W      = 16;
  localparam int unsigned FUN_KEY_W  = 3;
  localparam int unsigned MTX_KEY_W  = 5;
  localparam int unsigned KNOB_W     = 32;
  localparam int unsigned DEB_W      = 16;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_BITS     = TS_W + FUN_LVL_W + MTX_W + ENC_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = FUN_KEY_W + MTX_KEY_W + KNOB_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Field offsets inside the output tdata.
  localparam int unsigned OUT_MTX_LSB   = FUN_KEY_W;
  localparam int unsigned OUT_KNOB_LSB  = FUN_KEY_W + MTX_KEY_W;
  localparam int unsigned OUT_AWAKE_BIT = FUN_KEY_W + MTX_KEY_W + KNOB_W;

  // Register file.
  localparam int unsigned PADDR_W            = 3;
  localparam int unsigned PDATA_W            = 32;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;
  localparam logic            REG_IDX_DEBOUNCE = 1'b0;

  // Highest legal key codes.
  localparam logic [FUN_KEY_W-1:0] FUN_KEY_MAX = 3'd6;
  localparam logic [MTX_KEY_W-1:0] MTX_KEY_MAX = 5'd16;

  // Debounce machine phases.
  typedef enum logic [1:0] {
    PH_SCAN           = 2'd0,
    PH_PRESS_FILTER   = 2'd1,
    PH_PRESSED        = 2'd2,
    PH_RELEASE_FILTER = 2'd3
  } phase_e;

endpackage

`default_nettype wire

/* rtl/hid_key_knob_scanner_core.sv */
// ----------------------------------------------------------------------------
// Key and knob scanner core
// Debounces six function keys and a 4x4 key matrix, and extends a 16-bit
// quadrature counter to a 32-bit knob position, one scan tick per transaction.
// ----------------------------------------------------------------------------
// Usage:
// Each slave-side transaction is one scan tick (timestamp, function key
// levels, matrix closures, encoder counter). Each tick yields exactly one
// master-side transaction with the tracked function key, the confirmed matrix
// key, the negated extended knob count and a stay-awake flag.
// A tick is taken into an input register, evaluated by the debounce and knob
// logic once the result register is free and written to the result register.
// One tick per cycle is sustained while the receiver keeps m_axis_tready
// high; the state is updated as a tick moves between the input and result
// registers.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more tick; only then does s_axis_tready drop.
// Reset clears both machines to scan, the knob count to zero, both registers
// to empty and debounce_ticks to 10. The user writes debounce_ticks over APB at
// byte address 0 only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_key_knob_scanner_core
  import hkks_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration port.
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic      [PDATA_W-1:0]     prdata,
  output logic                        pready,
  // Tick stream: timestamp[31:0], fun_key_levels[37:32],
  // matrix_closed[53:38], encoder_count[69:54], zero padding[71:70].
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream: fun_key[2:0], matrix_key[7:3], knob_position[39:8],
  // stay_awake[40], zero padding[47:41].
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [DEB_W-1:0] debounce_q;
  logic             reg_hit;
  logic             reg_wr;

  assign reg_hit = (paddr[2] == REG_IDX_DEBOUNCE);
  assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(PDATA_W-DEB_W){1'b0}}, debounce_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (reg_wr) begin
      debounce_q <= pwdata[DEB_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic                  in_valid_q;
  logic [IN_BITS-1:0]    in_data_q;
  logic                  res_valid_q;
  logic [OUT_BITS-1:0]   res_data_q;
  logic [OUT_BITS-1:0]   res_data_d;
  logic                  res_free;
  logic                  fire;
  logic                  load;

  assign res_free      = !res_valid_q || m_axis_tready;
  assign fire          = in_valid_q && res_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (load) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_data_q <= s_axis_tdata[IN_BITS-1:0];
    end
    if (fire) begin
      res_data_q <= res_data_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, res_data_q};

  // Unpack the registered tick.
  logic [TS_W-1:0]      now;
  logic [FUN_LVL_W-1:0] levels;
  logic [MTX_W-1:0]     closed;
  logic [ENC_W-1:0]     enc_cur;

  assign now     = in_data_q[TS_W-1:0];
  assign levels  = in_data_q[TS_W +: FUN_LVL_W];
  assign closed  = in_data_q[TS_W+FUN_LVL_W +: MTX_W];
  assign enc_cur = in_data_q[TS_W+FUN_LVL_W+MTX_W +: ENC_W];

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  phase_e               fun_phase_q, fun_phase_d;
  logic [FUN_KEY_W-1:0] fun_cand_q, fun_cand_d;
  logic [TS_W-1:0]      fun_mark_q, fun_mark_d;
  phase_e               mtx_phase_q, mtx_phase_d;
  logic [2:0]           mtx_row_q, mtx_row_d;
  logic [2:0]           mtx_col_q, mtx_col_d;
  logic [TS_W-1:0]      mtx_mark_q, mtx_mark_d;
  logic [ENC_W-1:0]     enc_prev_q;
  logic [ENC_W-1:0]     wrap_q, wrap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fun_phase_q <= PH_SCAN;
      fun_cand_q  <= '0;
      fun_mark_q  <= '0;
      mtx_phase_q <= PH_SCAN;
      mtx_row_q   <= '0;
      mtx_col_q   <= '0;
      mtx_mark_q  <= '0;
      enc_prev_q  <= '0;
      wrap_q      <= '0;
    end else if (fire) begin
      fun_phase_q <= fun_phase_d;
      fun_cand_q  <= fun_cand_d;
      fun_mark_q  <= fun_mark_d;
      mtx_phase_q <= mtx_phase_d;
      mtx_row_q   <= mtx_row_d;
      mtx_col_q   <= mtx_col_d;
      mtx_mark_q  <= mtx_mark_d;
      enc_prev_q  <= enc_cur;
      wrap_q      <= wrap_d;
    end
  end

  // --------------------------------------------------------------------------
  // Function key machine, next state
  // --------------------------------------------------------------------------
  logic [FUN_KEY_W-1:0] fun_pick;
  logic                 fun_elapsed;
  logic                 fun_held;

  assign fun_elapsed = (now - fun_mark_q) > {{(TS_W-DEB_W){1'b0}}, debounce_q};

  // Lowest-numbered function key whose pin is low.
  always_comb begin
    fun_pick = '0;
    for (int k = FUN_LVL_W - 1; k >= 0; k--) begin
      if (!levels[k]) begin
        fun_pick = FUN_KEY_W'(k + 1);
      end
    end
  end

  // Is the tracked candidate still down?
  always_comb begin
    fun_held = 1'b0;
    if (fun_cand_q != '0 && fun_cand_q <= FUN_KEY_MAX) begin
      fun_held = !levels[fun_cand_q - 3'd1];
    end
  end

  always_comb begin
    fun_phase_d = fun_phase_q;
    fun_cand_d  = fun_cand_q;
    fun_mark_d  = fun_mark_q;
    unique case (fun_phase_q)
      PH_SCAN: begin
        fun_cand_d = fun_pick;
        if (fun_pick != '0) begin
          fun_mark_d  = now;
          fun_phase_d = PH_PRESS_FILTER;
        end
      end
      PH_PRESS_FILTER: begin
        if (fun_elapsed) begin
          fun_phase_d = fun_held ? PH_PRESSED : PH_SCAN;
        end
      end
      PH_PRESSED: begin
        if (!fun_held) begin
          fun_mark_d  = now;
          fun_phase_d = PH_RELEASE_FILTER;
        end
      end
      PH_RELEASE_FILTER: begin
        if (fun_elapsed) begin
          if (!fun_held) begin
            fun_cand_d  = '0;
            fun_phase_d = PH_SCAN;
          end else begin
            fun_phase_d = PH_PRESSED;
          end
        end
      end
      default: begin
        fun_phase_d = PH_SCAN;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Matrix key machine, next state
  // --------------------------------------------------------------------------
  logic [2:0] mtx_pick;
  logic [3:0] row_bits;
  logic [2:0] col_code;
  logic       mtx_elapsed;
  logic       mtx_held;

  assign mtx_elapsed = (now - mtx_mark_q) > {{(TS_W-DEB_W){1'b0}}, debounce_q};

  // Lowest row with any closure.
  always_comb begin
    mtx_pick = '0;
    for (int r = 3; r >= 0; r--) begin
      if (closed[4*r +: 4] != 4'd0) begin
        mtx_pick = 3'(r + 1);
      end
    end
  end

  // Closures of the tracked row; rows outside one to four read as open.
  always_comb begin
    unique case (mtx_row_q)
      3'd1:    row_bits = closed[3:0];
      3'd2:    row_bits = closed[7:4];
      3'd3:    row_bits = closed[11:8];
      3'd4:    row_bits = closed[15:12];
      default: row_bits = 4'd0;
    endcase
  end

  // Column of a single closure, zero when the row has none or several.
  always_comb begin
    unique case (row_bits)
      4'b0001: col_code = 3'd1;
      4'b0010: col_code = 3'd2;
      4'b0100: col_code = 3'd3;
      4'b1000: col_code = 3'd4;
      default: col_code = 3'd0;
    endcase
  end

  // Held only while the row shows exactly the tracked column.
  assign mtx_held = (mtx_col_q != 3'd0) && (col_code == mtx_col_q);

  always_comb begin
    mtx_phase_d = mtx_phase_q;
    mtx_row_d   = mtx_row_q;
    mtx_col_d   = mtx_col_q;
    mtx_mark_d  = mtx_mark_q;
    unique case (mtx_phase_q)
      PH_SCAN: begin
        mtx_row_d = mtx_pick;
        if (mtx_pick != 3'd0) begin
          mtx_mark_d  = now;
          mtx_phase_d = PH_PRESS_FILTER;
        end
      end
      PH_PRESS_FILTER: begin
        if (mtx_elapsed) begin
          mtx_phase_d = PH_SCAN;
          if (row_bits != 4'd0) begin
            mtx_col_d = col_code;
            if (col_code != 3'd0) begin
              mtx_phase_d = PH_PRESSED;
            end
          end
        end
      end
      PH_PRESSED: begin
        if (!mtx_held) begin
          mtx_mark_d  = now;
          mtx_phase_d = PH_RELEASE_FILTER;
        end
      end
      PH_RELEASE_FILTER: begin
        if (mtx_elapsed) begin
          if (!mtx_held) begin
            mtx_row_d   = 3'd0;
            mtx_col_d   = 3'd0;
            mtx_phase_d = PH_SCAN;
          end else begin
            mtx_phase_d = PH_PRESSED;
          end
        end
      end
      default: begin
        mtx_phase_d = PH_SCAN;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Knob wrap tracking
  // --------------------------------------------------------------------------
  // A sign flip with a short step is a wrap through zero; a long step is a
  // crossing of the midpoint and leaves the wrap count alone.
  logic signed [ENC_W+1:0] enc_step;
  logic                    sign_flip;
  logic                    short_step;

  assign enc_step   = $signed({{2{enc_cur[ENC_W-1]}}, enc_cur})
                    - $signed({{2{enc_prev_q[ENC_W-1]}}, enc_prev_q});
  assign sign_flip  = enc_cur[ENC_W-1] != enc_prev_q[ENC_W-1];
  assign short_step = (enc_step > -18'sd32768) && (enc_step < 18'sd32768);

  always_comb begin
    wrap_d = wrap_q;
    if (sign_flip && short_step) begin
      if (enc_step[ENC_W+1]) begin
        wrap_d = wrap_q - 16'd1;
      end else begin
        wrap_d = wrap_q + 16'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result formatting
  // --------------------------------------------------------------------------
  logic [KNOB_W-1:0]    knob_before;
  logic [KNOB_W-1:0]    knob_after;
  logic [MTX_KEY_W-1:0] mtx_key;
  logic [1:0]           row_m1;
  logic                 awake;

  assign knob_before = {wrap_q, enc_prev_q};
  assign knob_after  = {wrap_d, enc_cur};
  assign row_m1      = 2'(mtx_row_d - 3'd1);

  always_comb begin
    mtx_key = '0;
    if (mtx_col_d != 3'd0 && mtx_row_d >= 3'd1 && mtx_row_d <= 3'd4) begin
      mtx_key = {1'b0, row_m1, 2'b00} + {2'b00, mtx_col_d};
    end
  end

  assign awake = (knob_before != knob_after) || (fun_cand_d != '0) || (mtx_key != '0);

  assign res_data_d = {awake, KNOB_W'(-knob_after), mtx_key, fun_cand_d};

endmodule

`default_nettype wire

/* rtl/hkks_checker.sv */
// ----------------------------------------------------------------------------
// Key and knob scanner port checker
// Watches the result stream of the scanner core for legal codes and holding.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hid_key_knob_scanner_core_defines.svh"

module hkks_checker
  import hkks_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [FUN_KEY_W-1:0] fun_key;
  logic [MTX_KEY_W-1:0] mtx_key;
  logic                 awake;

  assign fun_key = m_axis_tdata[FUN_KEY_W-1:0];
  assign mtx_key = m_axis_tdata[OUT_MTX_LSB +: MTX_KEY_W];
  assign awake   = m_axis_tdata[OUT_AWAKE_BIT];

  // A stalled result stays offered with the same contents.
  `HKKS_ASSERT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Key codes stay within their legal ranges.
  `HKKS_ASSERT(a_fun_range, clk_i, rst_ni, m_axis_tvalid |-> fun_key <= FUN_KEY_MAX, "function key code out of range")
  `HKKS_ASSERT(a_mtx_range, clk_i, rst_ni, m_axis_tvalid |-> mtx_key <= MTX_KEY_MAX, "matrix key code out of range")

  // Any reported key keeps the host awake.
  `HKKS_ASSERT(a_awake_key, clk_i, rst_ni, m_axis_tvalid && (fun_key != '0 || mtx_key != '0) |-> awake, "key reported without stay-awake")

  // Once reset has been seen at an edge, nothing is offered at the next one.
  `HKKS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "result offered during reset")

endmodule

bind hid_key_knob_scanner_core hkks_checker u_hkks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
